// ===== hdl/esrs_pkg.sv =====
// ----------------------------------------------------------------------------
// esrs_pkg
// Shared types, codes and the frame parity function for the encoder
// register-read sequencer.
// ----------------------------------------------------------------------------
package esrs_pkg;

  localparam logic [1:0] OP_START_RAW   = 2'd0;
  localparam logic [1:0] OP_START_ANGLE = 2'd1;
  localparam logic [1:0] OP_FRAME_DONE  = 2'd2;

  localparam logic [2:0] KIND_SEND       = 3'd0;
  localparam logic [2:0] KIND_RAW_DONE   = 3'd1;
  localparam logic [2:0] KIND_ANGLE_OK   = 3'd2;
  localparam logic [2:0] KIND_ANGLE_FAIL = 3'd3;
  localparam logic [2:0] KIND_REJECT     = 3'd4;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_CMD  = 2'd1;
  localparam logic [1:0] PH_NOP  = 2'd2;

  localparam logic [1:0] REG_MAX_ATTEMPTS = 2'd0;

  localparam logic [13:0] ANGLE_ADDR      = 14'h3FFF;
  localparam logic [15:0] READ_NOP        = 16'hC000;
  localparam logic [3:0]  MAX_ATTEMPTS_RST = 4'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [13:0] reg_address;
    logic [15:0] rx_word;
  } item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] tx_word;
    logic [15:0] read_value;
  } result_t;

  function automatic logic parity15(input logic [15:0] w);
    return ^w[14:0];
  endfunction

  function automatic logic [15:0] read_command(input logic [13:0] addr);
    logic [15:0] cmd;
    cmd = {2'b01, addr};
    cmd[15] = parity15(cmd);
    return cmd;
  endfunction

endpackage

// ===== hdl/esrs_seq.sv =====
// ----------------------------------------------------------------------------
// esrs_seq
// Sequencer state and the per-request decision: builds command frames,
// checks angle replies and handles retries.
// ----------------------------------------------------------------------------
module esrs_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  esrs_pkg::item_t     item,
  input  logic [3:0]          max_attempts,
  output esrs_pkg::result_t   res
);

  logic [1:0]  phase_r, phase_nxt;
  logic        angle_mode_r, angle_mode_nxt;
  logic [3:0]  attempts_r, attempts_nxt;
  logic [15:0] held_cmd_r, held_cmd_nxt;
  logic        busy;
  logic        reply_good;

  assign busy = (phase_r == esrs_pkg::PH_CMD) || (phase_r == esrs_pkg::PH_NOP);
  assign reply_good = !item.rx_word[14] &&
                      (esrs_pkg::parity15(item.rx_word) == item.rx_word[15]);

  always_comb begin
    phase_nxt      = phase_r;
    angle_mode_nxt = angle_mode_r;
    attempts_nxt   = attempts_r;
    held_cmd_nxt   = held_cmd_r;
    res            = '{kind: esrs_pkg::KIND_REJECT, tx_word: 16'd0, read_value: 16'd0};
    case (item.opcode)
      esrs_pkg::OP_START_RAW, esrs_pkg::OP_START_ANGLE: begin
        if (!busy) begin
          angle_mode_nxt = item.opcode[0];
          attempts_nxt   = {3'd0, item.opcode[0]};
          held_cmd_nxt   = esrs_pkg::read_command(item.opcode[0] ? esrs_pkg::ANGLE_ADDR
                                                                 : item.reg_address);
          phase_nxt      = esrs_pkg::PH_CMD;
          res.kind       = esrs_pkg::KIND_SEND;
          res.tx_word    = held_cmd_nxt;
        end
      end
      esrs_pkg::OP_FRAME_DONE: begin
        if (phase_r == esrs_pkg::PH_CMD) begin
          phase_nxt   = esrs_pkg::PH_NOP;
          res.kind    = esrs_pkg::KIND_SEND;
          res.tx_word = esrs_pkg::READ_NOP;
        end else if (phase_r == esrs_pkg::PH_NOP) begin
          if (!angle_mode_r) begin
            phase_nxt      = esrs_pkg::PH_IDLE;
            res.kind       = esrs_pkg::KIND_RAW_DONE;
            res.read_value = item.rx_word;
          end else if (reply_good) begin
            phase_nxt      = esrs_pkg::PH_IDLE;
            res.kind       = esrs_pkg::KIND_ANGLE_OK;
            res.read_value = {2'b00, item.rx_word[13:0]};
          end else if (attempts_r < max_attempts) begin
            attempts_nxt = attempts_r + 4'd1;
            phase_nxt    = esrs_pkg::PH_CMD;
            res.kind     = esrs_pkg::KIND_SEND;
            res.tx_word  = held_cmd_r;
          end else begin
            phase_nxt = esrs_pkg::PH_IDLE;
            res.kind  = esrs_pkg::KIND_ANGLE_FAIL;
          end
        end
      end
      default: begin
        res.kind = esrs_pkg::KIND_REJECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= esrs_pkg::PH_IDLE;
      angle_mode_r <= 1'b0;
      attempts_r   <= 4'd0;
      held_cmd_r   <= 16'd0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      angle_mode_r <= angle_mode_nxt;
      attempts_r   <= attempts_nxt;
      held_cmd_r   <= held_cmd_nxt;
    end
  end

endmodule

// ===== hdl/encoder_spi_read_sequencer.sv =====
// ----------------------------------------------------------------------------
// encoder_spi_read_sequencer
// Requests pass through the input register, then the result register.
// Accepts one request per cycle; an output stall holds both registers
// and stalls the input in the same cycle.
// Reset (synchronous, rst_n low): idle phase, pipeline empty,
// max_attempts = 3.
// ----------------------------------------------------------------------------
module encoder_spi_read_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [13:0] in_reg_address,
  input  logic [15:0] in_rx_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [15:0] out_tx_word,
  output logic [15:0] out_read_value,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic              s1_valid_r;
  esrs_pkg::item_t   s1_item_r;
  logic              out_valid_r;
  esrs_pkg::result_t out_res_r;
  esrs_pkg::result_t res;
  logic [3:0]        max_attempts_r;
  logic              advance;
  logic              in_fire;

  assign pready  = 1'b1;
  assign prdata  = {28'd0, max_attempts_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_attempts_r <= esrs_pkg::MAX_ATTEMPTS_RST;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == esrs_pkg::REG_MAX_ATTEMPTS)) begin
      max_attempts_r <= pwdata[3:0];
    end
  end

  assign advance  = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= '{opcode: in_opcode, reg_address: in_reg_address, rx_word: in_rx_word};
    end
  end

  esrs_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance),
    .item         (s1_item_r),
    .max_attempts (max_attempts_r),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_res_r.kind;
  assign out_tx_word    = out_res_r.tx_word;
  assign out_read_value = out_res_r.read_value;

endmodule
